@@ hw/rtl/trd_pkg.sv @@
// ----------------------------------------------------------------------------
// trd_pkg
// Shared widths, codes and handshake structs of the triangle rasteriser.
// ----------------------------------------------------------------------------
package trd_pkg;

  // Default parameter values.
  localparam int MaxWidthDef  = 256;
  localparam int MaxHeightDef = 256;
  localparam int DepthBitsDef = 16;

  // Fixed arithmetic widths, set by the 8-bit vertex fields.
  localparam int WGT_W = 21;  // doubled edge weight
  localparam int ZIN_W = 16;  // vertex depth
  localparam int NUM_W = 39;  // sum of three weight-depth products
  localparam int DVS_W = 20;  // twice the signed area
  localparam int QUO_W = 17;  // quotient magnitude bits
  localparam int ZQ_W  = 18;  // signed quotient

  // Input operations.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [3:0] ST_ACCEPTED  = 4'd0;
  localparam logic [3:0] ST_DEGEN     = 4'd1;
  localparam logic [3:0] ST_CULLED    = 4'd2;
  localparam logic [3:0] ST_OUTSIDE   = 4'd3;
  localparam logic [3:0] ST_CLIPPED   = 4'd4;
  localparam logic [3:0] ST_FAILED    = 4'd5;
  localparam logic [3:0] ST_WRITTEN   = 4'd6;
  localparam logic [3:0] ST_CLEARED   = 4'd7;
  localparam logic [3:0] ST_IDLE      = 4'd8;

  // Configuration register indexes.
  localparam logic [1:0] REG_CULL  = 2'd0;
  localparam logic [1:0] REG_DTEST = 2'd1;
  localparam logic [1:0] REG_VW    = 2'd2;
  localparam logic [1:0] REG_VH    = 2'd3;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] dividend;
    logic signed [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [ZQ_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ hw/rtl/trd_divider.sv @@
// ----------------------------------------------------------------------------
// trd_divider
// Signed restoring divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module trd_divider (
  input  logic              clk,
  input  logic              rst,
  input  trd_pkg::div_req_t req,
  output trd_pkg::div_rsp_t rsp
);
  import trd_pkg::*;

  localparam int MAG_W = NUM_W - 1;
  localparam int CNT_W = $clog2(QUO_W + 1);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [MAG_W-1:0] rem;
  logic [MAG_W-1:0] dsh;
  logic [QUO_W-1:0] quo;
  logic             neg;
  logic [MAG_W-1:0] n_mag;
  logic [MAG_W-1:0] d_mag;
  logic             bit_ok;
  logic [QUO_W-1:0] quo_fin;

  assign n_mag  = req.dividend[NUM_W-1] ? MAG_W'(-req.dividend) : MAG_W'(req.dividend);
  assign d_mag  = req.divisor[DVS_W-1] ? MAG_W'(-req.divisor) : MAG_W'(req.divisor);
  assign bit_ok = rem >= dsh;
  assign quo_fin = {quo[QUO_W-2:0], bit_ok};

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(QUO_W);
        rem     <= n_mag;
        dsh     <= d_mag << (QUO_W - 1);
        quo     <= '0;
        neg     <= req.dividend[NUM_W-1] ^ req.divisor[DVS_W-1];
      end else if (running) begin
        // Take one quotient bit, then narrow the shifted divisor.
        if (bit_ok) rem <= rem - dsh;
        quo <= {quo[QUO_W-2:0], bit_ok};
        dsh <= dsh >> 1;
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          // Quotient is taken from the last iteration; sign applied on the way out.
          running      <= 1'b0;
          rsp.done     <= 1'b1;
          rsp.quotient <= neg ? -ZQ_W'(quo_fin) : ZQ_W'(quo_fin);
        end
      end
    end
  end

endmodule

@@ hw/rtl/trd_depth_mem.sv @@
// ----------------------------------------------------------------------------
// trd_depth_mem
// Depth store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module trd_depth_mem #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);
  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/triangle_raster_depth_test.sv @@
// ----------------------------------------------------------------------------
// triangle_raster_depth_test
// Edge-function triangle rasteriser with an on-chip depth store and test.
// ----------------------------------------------------------------------------
//  channel   signals                                      beat
//  command   start/busy, op, vert*_x/y, vert*_depth       start && !busy
//  result    done, status, pix_x/y, weight_*, frag_depth, last   done
//  config    wr_en, wr_index, wr_data                      wr_en
//
//  One command beat at a time; busy is high until its result beat is out.
//  A load runs through edge, area and weight set-up, or stops after the area
//  check when rejected. Clear and idle answers come from dispatch, and a step
//  for an uncovered pixel is answered when the pixel is visited. A covered
//  pixel that is clipped or out of view is answered after the divider; else
//  it goes through a weight-depth multiply-accumulate over the three vertices,
//  the divider start, the quotient handover, then the depth store read and
//  write-back. After reset the store is swept to farthest depth, one entry a cycle, with busy high.
//  The result beat lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module triangle_raster_depth_test #(
  parameter int MAX_WIDTH  = trd_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = trd_pkg::MaxHeightDef,
  parameter int DEPTH_BITS = trd_pkg::DepthBitsDef
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                op,
  input  logic [7:0]                vert0_x,
  input  logic [7:0]                vert0_y,
  input  logic [7:0]                vert1_x,
  input  logic [7:0]                vert1_y,
  input  logic [7:0]                vert2_x,
  input  logic [7:0]                vert2_y,
  input  logic signed [15:0]        vert0_depth,
  input  logic signed [15:0]        vert1_depth,
  input  logic signed [15:0]        vert2_depth,
  input  logic                      wr_en,
  input  logic [1:0]                wr_index,
  input  logic [8:0]                wr_data,
  output logic                      done,
  output logic [3:0]                status,
  output logic [7:0]                pix_x,
  output logic [7:0]                pix_y,
  output logic signed [20:0]        weight_a,
  output logic signed [20:0]        weight_b,
  output logic signed [20:0]        weight_c,
  output logic signed [15:0]        frag_depth,
  output logic                      last
);
  import trd_pkg::*;

  localparam int STORE  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(STORE);
  localparam int EW_W   = $clog2(MAX_WIDTH + 1) + 1;
  localparam int EH_W   = $clog2(MAX_HEIGHT + 1) + 1;
  localparam int PROD_W = 8 + EW_W + 1;
  localparam logic signed [33:0] Z_FAR = 34'((64'd1 << (DEPTH_BITS - 1)) - 1);
  localparam logic signed [33:0] Z_NEAR = -Z_FAR - 34'sd1;
  localparam logic signed [ZQ_W-1:0] Z_ONE = ZQ_W'(16384);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_L1    = 4'd3;
  localparam logic [3:0] S_L2    = 4'd4;
  localparam logic [3:0] S_L3    = 4'd5;
  localparam logic [3:0] S_V0    = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_RD    = 4'd9;
  localparam logic [3:0] S_CMP   = 4'd10;

  logic [3:0] state;
  logic [ADDR_W-1:0] clr_cnt;

  // Configuration.
  logic       cull_enable, depth_test_enable;
  logic [8:0] view_width, view_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      cull_enable       <= 1'b0;
      depth_test_enable <= 1'b0;
      view_width        <= 9'd256;
      view_height       <= 9'd256;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CULL:  cull_enable       <= wr_data[0];
        REG_DTEST: depth_test_enable <= wr_data[0];
        REG_VW:    view_width        <= wr_data;
        REG_VH:    view_height       <= wr_data;
        default:   ;
      endcase
    end
  end

  // Saturate the viewport into its legal range.
  logic [EW_W-1:0] ew;
  logic [EH_W-1:0] eh;
  always_comb begin
    if (EW_W'(view_width) < EW_W'(2)) ew = EW_W'(2);
    else if (EW_W'(view_width) > EW_W'(MAX_WIDTH)) ew = EW_W'(MAX_WIDTH);
    else ew = EW_W'(view_width);
    if (EH_W'(view_height) < EH_W'(2)) eh = EH_W'(2);
    else if (EH_W'(view_height) > EH_W'(MAX_HEIGHT)) eh = EH_W'(MAX_HEIGHT);
    else eh = EH_W'(view_height);
  end

  // Captured command.
  logic [1:0]               in_op;
  logic [7:0]               in_x [3];
  logic [7:0]               in_y [3];
  logic signed [ZIN_W-1:0]  in_z [3];

  // Triangle state.
  logic                     tri_active;
  logic signed [8:0]        ea [3];
  logic signed [8:0]        eb [3];
  logic signed [17:0]       ec [3];
  logic signed [ZIN_W-1:0]  tz [3];
  logic signed [17:0]       area;
  logic [7:0]               bx0, by0, bx1, by1;
  logic [7:0]               cx, cy;
  logic signed [WGT_W-1:0]  roww [3];
  logic signed [WGT_W-1:0]  curw [3];

  // Per-pixel working state.
  logic signed [WGT_W-1:0]  pw [3];
  logic [1:0]               mk;
  logic signed [NUM_W-1:0]  num;
  logic [ADDR_W-1:0]        addr;
  logic                     in_view;
  logic                     last_r;
  logic signed [ZQ_W-1:0]   zr;

  // Edge coefficients from the captured vertices.
  logic signed [8:0]  na [3];
  logic signed [8:0]  nb [3];
  logic signed [17:0] nc [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      na[k] = $signed({1'b0, in_y[(k+1)%3]}) - $signed({1'b0, in_y[(k+2)%3]});
      nb[k] = $signed({1'b0, in_x[(k+2)%3]}) - $signed({1'b0, in_x[(k+1)%3]});
      nc[k] = $signed({2'b0, 16'(in_y[(k+2)%3] * in_x[(k+1)%3])})
            - $signed({2'b0, 16'(in_x[(k+2)%3] * in_y[(k+1)%3])});
    end
  end

  // Bounding box clamped to the viewport.
  logic [7:0] lo_x, hi_x, lo_y, hi_y;
  logic [EW_W-1:0] lim_x;
  logic [EH_W-1:0] lim_y;
  always_comb begin
    lo_x = in_x[0]; hi_x = in_x[0]; lo_y = in_y[0]; hi_y = in_y[0];
    for (int v = 1; v < 3; v++) begin
      if (in_x[v] < lo_x) lo_x = in_x[v];
      if (in_x[v] > hi_x) hi_x = in_x[v];
      if (in_y[v] < lo_y) lo_y = in_y[v];
      if (in_y[v] > hi_y) hi_y = in_y[v];
    end
    lim_x = ew - 1'b1;
    lim_y = eh - 1'b1;
  end

  logic signed [19:0] area_sum;
  assign area_sum = 20'(ea[2] * $signed({1'b0, in_x[2]}))
                  + 20'(eb[2] * $signed({1'b0, in_y[2]})) + 20'(ec[2]);

  logic signed [21:0] w_init [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      w_init[k] = 22'sd2 * (22'(ea[k] * $signed({1'b0, bx0}))
                + 22'(eb[k] * $signed({1'b0, by0})) + 22'(ec[k]))
                + 22'(ea[k]) + 22'(eb[k]);
    end
  end

  // Coverage: every weight agrees with the sign of the area.
  logic covered;
  always_comb begin
    covered = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if ((area > 0 && curw[k] < 0) || (area < 0 && curw[k] > 0)) covered = 1'b0;
    end
  end

  logic [PROD_W-1:0] pix_lin, clr_lin;
  assign pix_lin = PROD_W'(cy * ew) + PROD_W'(cx);
  assign clr_lin = PROD_W'(in_y[0] * ew) + PROD_W'(in_x[0]);

  logic signed [NUM_W-1:0] num_next;
  assign num_next = num + NUM_W'(pw[mk] * tz[mk]);

  // Divider.
  div_req_t dreq;
  div_rsp_t drsp;
  logic     div_start;
  assign dreq.start    = div_start;
  assign dreq.dividend = num;
  assign dreq.divisor  = DVS_W'(area) <<< 1;

  trd_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // Depth store.
  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [DEPTH_BITS-1:0] mem_wdata, mem_rdata;
  logic signed [33:0]    z_ext, z_sat, stored;
  logic                  fail;

  assign z_ext  = 34'(zr);
  assign z_sat  = (z_ext > Z_FAR) ? Z_FAR : ((z_ext < Z_NEAR) ? Z_NEAR : z_ext);
  assign stored = 34'($signed(mem_rdata));
  assign fail   = depth_test_enable && (z_ext > stored);
  assign mem_re = (state == S_RD);

  logic clr_hit;
  assign clr_hit = (EW_W'(in_x[0]) < ew) && (EH_W'(in_y[0]) < eh);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = DEPTH_BITS'(Z_FAR);
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
      end
      S_DISP: begin
        mem_we    = (in_op == OP_CLEAR) && clr_hit;
        mem_waddr = clr_lin[ADDR_W-1:0];
      end
      S_CMP: begin
        mem_we    = !fail;
        mem_wdata = z_sat[DEPTH_BITS-1:0];
      end
      default: ;
    endcase
  end

  trd_depth_mem #(.ADDR_W(ADDR_W), .DATA_W(DEPTH_BITS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr),
    .rdata (mem_rdata)
  );

  assign busy = (state != S_IDLE);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      tri_active <= 1'b0;
      done       <= 1'b0;
      div_start  <= 1'b0;
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          // Sweep the store to farthest depth, one entry a cycle.
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ADDR_W'(STORE - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            in_op <= op;
            in_x[0] <= vert0_x; in_x[1] <= vert1_x; in_x[2] <= vert2_x;
            in_y[0] <= vert0_y; in_y[1] <= vert1_y; in_y[2] <= vert2_y;
            in_z[0] <= vert0_depth; in_z[1] <= vert1_depth; in_z[2] <= vert2_depth;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          pix_x <= '0; pix_y <= '0;
          weight_a <= '0; weight_b <= '0; weight_c <= '0;
          frag_depth <= '0;
          last <= 1'b0;
          unique case (in_op)
            OP_LOAD: state <= S_L1;
            OP_STEP: begin
              if (tri_active) begin
                state <= S_V0;
              end else begin
                status <= ST_IDLE;
                done   <= 1'b1;
                state  <= S_IDLE;
              end
            end
            OP_CLEAR: begin
              // When the entry lies in the viewport, the write happens this cycle through the store's write port.
              status <= clr_hit ? ST_CLEARED : ST_IDLE;
              done   <= 1'b1;
              state  <= S_IDLE;
            end
            default: begin
              status <= ST_IDLE;
              done   <= 1'b1;
              state  <= S_IDLE;
            end
          endcase
        end
        S_L1: begin
          // Abandon any triangle in flight; latch edges, depths and box.
          tri_active <= 1'b0;
          for (int k = 0; k < 3; k++) begin
            ea[k] <= na[k];
            eb[k] <= nb[k];
            ec[k] <= nc[k];
            tz[k] <= in_z[k];
          end
          bx0 <= (EW_W'(lo_x) > lim_x) ? lim_x[7:0] : lo_x;
          bx1 <= (EW_W'(hi_x) > lim_x) ? lim_x[7:0] : hi_x;
          by0 <= (EH_W'(lo_y) > lim_y) ? lim_y[7:0] : lo_y;
          by1 <= (EH_W'(hi_y) > lim_y) ? lim_y[7:0] : hi_y;
          state <= S_L2;
        end
        S_L2: begin
          area <= area_sum[17:0];
          if (area_sum == 0) begin
            status <= ST_DEGEN;
            last   <= 1'b1;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (cull_enable && area_sum < 0) begin
            status <= ST_CULLED;
            last   <= 1'b1;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_L3;
          end
        end
        S_L3: begin
          for (int k = 0; k < 3; k++) begin
            roww[k] <= w_init[k][WGT_W-1:0];
            curw[k] <= w_init[k][WGT_W-1:0];
          end
          cx <= bx0;
          cy <= by0;
          tri_active <= 1'b1;
          status <= ST_ACCEPTED;
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_V0: begin
          // Report the pixel, then advance the cursor in raster order.
          pix_x <= cx; pix_y <= cy;
          weight_a <= curw[0]; weight_b <= curw[1]; weight_c <= curw[2];
          for (int k = 0; k < 3; k++) pw[k] <= curw[k];
          addr    <= pix_lin[ADDR_W-1:0];
          in_view <= (EW_W'(cx) < ew) && (EH_W'(cy) < eh);
          if (cx < bx1) begin
            cx <= cx + 1'b1;
            for (int k = 0; k < 3; k++) curw[k] <= curw[k] + (WGT_W'(ea[k]) <<< 1);
            last_r <= 1'b0;
          end else if (cy < by1) begin
            cy <= cy + 1'b1;
            cx <= bx0;
            for (int k = 0; k < 3; k++) begin
              roww[k] <= roww[k] + (WGT_W'(eb[k]) <<< 1);
              curw[k] <= roww[k] + (WGT_W'(eb[k]) <<< 1);
            end
            last_r <= 1'b0;
          end else begin
            tri_active <= 1'b0;
            last_r     <= 1'b1;
          end
          if (!covered) begin
            status <= ST_OUTSIDE;
            last   <= !(cx < bx1) && !(cy < by1);
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            num   <= '0;
            mk    <= 2'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          num <= num_next;
          mk  <= mk + 1'b1;
          if (mk == 2'd2) begin
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            zr   <= drsp.quotient;
            last <= last_r;
            if (drsp.quotient < -Z_ONE || drsp.quotient > Z_ONE) begin
              status     <= ST_CLIPPED;
              frag_depth <= drsp.quotient[15:0];
              done       <= 1'b1;
              state      <= S_IDLE;
            end else if (!in_view) begin
              status <= ST_OUTSIDE;
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          // Read issued this cycle; data lands for the compare.
          state <= S_CMP;
        end
        S_CMP: begin
          frag_depth <= zr[15:0];
          status     <= fail ? ST_FAILED : ST_WRITTEN;
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
